FILE: hdl/cdq_pkg.sv
package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  // Command to one chain. The chain holds entries in order starting at cell 0.
  typedef struct packed {
    logic push_head;  // shift toward the far end, new entry into cell 0
    logic pop_head;   // shift toward cell 0
    logic push_tail;  // write the new entry into the cell right after the last one
  } chain_cmd_t;

  // Control of a single cell.
  typedef struct packed {
    logic ld;   // take the broadcast value
    logic shr;  // take the neighbor on the cell 0 side
    logic shl;  // take the neighbor on the far side
  } cell_ctl_t;

endpackage

FILE: hdl/cdq_cell.sv
module cdq_cell (
  input  logic                            clk,
  input  cdq_pkg::cell_ctl_t              ctl,
  input  logic signed [cdq_pkg::DATA_W-1:0] din,
  input  logic signed [cdq_pkg::DATA_W-1:0] from_prev,
  input  logic signed [cdq_pkg::DATA_W-1:0] from_next,
  output logic signed [cdq_pkg::DATA_W-1:0] q
);

  logic signed [cdq_pkg::DATA_W-1:0] q_r;
  logic signed [cdq_pkg::DATA_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.ld) begin
      q_nxt = din;
    end else if (ctl.shr) begin
      q_nxt = from_prev;
    end else if (ctl.shl) begin
      q_nxt = from_next;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

FILE: hdl/cdq_chain.sv
module cdq_chain (
  input  logic                              clk,
  input  cdq_pkg::chain_cmd_t               cmd,
  input  logic signed [cdq_pkg::DATA_W-1:0] value,
  input  logic [cdq_pkg::CNT_W-1:0]         count,
  output logic signed [cdq_pkg::DATA_W-1:0] head
);

  logic signed [cdq_pkg::DATA_W-1:0] q [cdq_pkg::DEPTH];

  for (genvar i = 0; i < cdq_pkg::DEPTH; i++) begin : g_cell
    cdq_pkg::cell_ctl_t                ctl;
    logic signed [cdq_pkg::DATA_W-1:0] prev_q;
    logic signed [cdq_pkg::DATA_W-1:0] next_q;

    // The cell at the current fill level takes a tail push.
    assign ctl.ld  = cmd.push_tail && (count == cdq_pkg::CNT_W'(i));
    assign ctl.shr = cmd.push_head;
    assign ctl.shl = cmd.pop_head;

    if (i == 0) begin : g_first
      assign prev_q = value;
    end else begin : g_mid
      assign prev_q = q[i-1];
    end

    if (i == cdq_pkg::DEPTH - 1) begin : g_last
      assign next_q = q[i];
    end else begin : g_inner
      assign next_q = q[i+1];
    end

    cdq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .din       (value),
      .from_prev (prev_q),
      .from_next (next_q),
      .q         (q[i])
    );
  end

  assign head = q[0];

endmodule

FILE: hdl/circular_deque.sv
// Channel  Direction  Ports                       Contents
// in_      slave      tvalid tready tdata tuser   tdata: item_value; tuser: kind
// out_     master     tvalid tready tdata tuser   tdata: popped_value, now_empty,
//                                                 now_full; tuser: status
// One transaction per cycle unless the output is stalled; every operation finishes
// in the cycle it is accepted, with its result in the output register on the next cycle.
// Two rows of cells hold the entries, one in front-to-back order and one in
// back-to-front order, so either end is always read at cell 0 of a row.
// Reset empties the deque at once; cell contents are not cleared.
// in_tready stays high while the output register is empty or being drained.
module circular_deque (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] item_value
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] popped_value, [32] now_empty, [33] now_full
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic                              accept;
  cdq_pkg::kind_t                    kind;
  logic signed [cdq_pkg::DATA_W-1:0] item_value;
  logic                              is_empty;
  logic                              is_full;

  logic [cdq_pkg::CNT_W-1:0]         count_r;
  logic [cdq_pkg::CNT_W-1:0]         count_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  cdq_pkg::status_t                  status_r;
  cdq_pkg::status_t                  status_nxt;
  logic signed [cdq_pkg::DATA_W-1:0] popped_r;
  logic signed [cdq_pkg::DATA_W-1:0] popped_nxt;
  logic                              empty_r;
  logic                              empty_nxt;
  logic                              full_r;
  logic                              full_nxt;

  cdq_pkg::chain_cmd_t               fwd_cmd;
  cdq_pkg::chain_cmd_t               rev_cmd;
  logic signed [cdq_pkg::DATA_W-1:0] front_q;
  logic signed [cdq_pkg::DATA_W-1:0] back_q;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign kind       = cdq_pkg::kind_t'(in_tuser);
  assign item_value = in_tdata;
  assign is_empty   = (count_r == '0);
  assign is_full    = (count_r == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));

  always_comb begin
    fwd_cmd       = '0;
    rev_cmd       = '0;
    count_nxt     = count_r;
    status_nxt    = status_r;
    popped_nxt    = popped_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = cdq_pkg::STATUS_DONE;
      popped_nxt    = '0;
      case (kind)
        cdq_pkg::KIND_PUSH_FRONT: begin
          if (is_full) begin
            status_nxt = cdq_pkg::STATUS_OVERFLOW;
          end else begin
            fwd_cmd.push_head = 1'b1;
            rev_cmd.push_tail = 1'b1;
            count_nxt         = count_r + 1'b1;
          end
        end
        cdq_pkg::KIND_PUSH_BACK: begin
          if (is_full) begin
            status_nxt = cdq_pkg::STATUS_OVERFLOW;
          end else begin
            rev_cmd.push_head = 1'b1;
            fwd_cmd.push_tail = 1'b1;
            count_nxt         = count_r + 1'b1;
          end
        end
        cdq_pkg::KIND_POP_FRONT: begin
          if (is_empty) begin
            status_nxt = cdq_pkg::STATUS_UNDERFLOW;
          end else begin
            // The other row loses its last entry through the fill count alone.
            fwd_cmd.pop_head = 1'b1;
            popped_nxt       = front_q;
            count_nxt        = count_r - 1'b1;
          end
        end
        cdq_pkg::KIND_POP_BACK: begin
          if (is_empty) begin
            status_nxt = cdq_pkg::STATUS_UNDERFLOW;
          end else begin
            rev_cmd.pop_head = 1'b1;
            popped_nxt       = back_q;
            count_nxt        = count_r - 1'b1;
          end
        end
        default: begin
          status_nxt = cdq_pkg::STATUS_DONE;
        end
      endcase
    end
    empty_nxt = (count_nxt == '0);
    full_nxt  = (count_nxt == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    popped_r <= popped_nxt;
    if (accept) begin
      empty_r <= empty_nxt;
      full_r  <= full_nxt;
    end
  end

  cdq_chain u_fwd_chain (
    .clk   (clk),
    .cmd   (fwd_cmd),
    .value (item_value),
    .count (count_r),
    .head  (front_q)
  );

  cdq_chain u_rev_chain (
    .clk   (clk),
    .cmd   (rev_cmd),
    .value (item_value),
    .count (count_r),
    .head  (back_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, full_r, empty_r, popped_r};
  assign out_tuser  = status_r;

endmodule

FILE: test/circular_deque_check.sv
`timescale 1ns / 1ps
module circular_deque_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          outstanding
);

  localparam int IDX_W = $clog2(cdq_pkg::DEPTH);

  typedef struct {
    cdq_pkg::status_t           status;
    logic [cdq_pkg::DATA_W-1:0] popped;
    logic                       now_empty;
    logic                       now_full;
  } op_result_t;

  logic [cdq_pkg::DATA_W-1:0] slot [cdq_pkg::DEPTH];
  logic [IDX_W-1:0]           front_at;
  logic [IDX_W-1:0]           back_at;
  logic                       held_none;
  op_result_t                 awaited [$];
  int                         errors;

  initial begin
    errors = 0;
    fail_count = 0;
    outstanding = 0;
  end

  function automatic logic [IDX_W-1:0] step_up(logic [IDX_W-1:0] i);
    return (int'(i) + 1 >= cdq_pkg::DEPTH) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] step_down(logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(cdq_pkg::DEPTH - 1) : i - 1'b1;
  endfunction

  function logic deque_full();
    return !held_none && step_up(back_at) == front_at;
  endfunction

  // Applies one operation to the shadow deque and returns the result it must produce.
  function op_result_t apply_op(cdq_pkg::kind_t k, logic [cdq_pkg::DATA_W-1:0] v);
    op_result_t r;
    r.status = cdq_pkg::STATUS_DONE;
    r.popped = '0;
    if (k == cdq_pkg::KIND_PUSH_FRONT || k == cdq_pkg::KIND_PUSH_BACK) begin
      if (deque_full()) begin
        r.status = cdq_pkg::STATUS_OVERFLOW;
      end else if (held_none) begin
        front_at = '0;
        back_at = '0;
        held_none = 1'b0;
        slot[0] = v;
      end else if (k == cdq_pkg::KIND_PUSH_FRONT) begin
        front_at = step_down(front_at);
        slot[front_at] = v;
      end else begin
        back_at = step_up(back_at);
        slot[back_at] = v;
      end
    end else if (held_none) begin
      r.status = cdq_pkg::STATUS_UNDERFLOW;
    end else begin
      r.popped = (k == cdq_pkg::KIND_POP_FRONT) ? slot[front_at] : slot[back_at];
      // Removing the only entry sends both ends back to slot 0.
      if (front_at == back_at) begin
        front_at = '0;
        back_at = '0;
        held_none = 1'b1;
      end else if (k == cdq_pkg::KIND_POP_FRONT) begin
        front_at = step_up(front_at);
      end else begin
        back_at = step_down(back_at);
      end
    end
    r.now_empty = held_none;
    r.now_full = deque_full();
    return r;
  endfunction

  always @(posedge clk) begin
    op_result_t want;
    if (!rst_n) begin
      front_at = '0;
      back_at = '0;
      held_none = 1'b1;
      awaited.delete();
    end else begin
      // A result never belongs to the operation accepted at the same edge,
      // so the output side is checked first.
      if (out_tvalid && out_tready) begin
        if (awaited.size() == 0) begin
          $error("unexpected result transaction: status %0d, popped_value %h",
                 out_tuser, out_tdata[31:0]);
          errors++;
        end else begin
          want = awaited.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            errors++;
          end
          if (out_tdata[31:0] !== want.popped) begin
            $error("popped_value: expected %h, got %h", want.popped, out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[32] !== want.now_empty) begin
            $error("now_empty: expected %0b, got %0b", want.now_empty, out_tdata[32]);
            errors++;
          end
          if (out_tdata[33] !== want.now_full) begin
            $error("now_full: expected %0b, got %0b", want.now_full, out_tdata[33]);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready)
        awaited.push_back(apply_op(cdq_pkg::kind_t'(in_tuser), in_tdata));
    end
    fail_count <= errors;
    outstanding <= awaited.size();
  end

endmodule

FILE: test/circular_deque_test.sv
`timescale 1ns / 1ps
module circular_deque_test;

  localparam int OP_TARGET = 1300;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] item_value
  logic [1:0]  in_tuser;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] popped_value, [32] now_empty, [33] now_full
  logic [1:0]  out_tuser;  // [1:0] status
  int          fail_count;
  int          outstanding;

  int          gap_max;
  int          sent;

  circular_deque u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  circular_deque_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Holds one operation on the input channel until the transaction completes.
  task automatic send_op(input cdq_pkg::kind_t k, input logic [31:0] v);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= k;
    in_tdata <= v;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // Result side: random stalls before each transaction, with stall-free stretches.
  initial begin
    int stall;
    int stall_max;
    int left;
    left = 0;
    stall_max = 5;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (left == 0) begin
        left = $urandom_range(10, 40);
        stall_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
      end
      left--;
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    int push_pct;
    int run_len;
    cdq_pkg::kind_t k;
    logic [31:0] v;
    sent = 0;
    gap_max = 5;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= cdq_pkg::KIND_PUSH_FRONT;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Pops on an empty deque, then a push into it from each end and a pop from each end.
    send_op(cdq_pkg::KIND_POP_FRONT, 32'hFFFF_FFFF);
    send_op(cdq_pkg::KIND_POP_BACK, 32'h0000_0000);
    send_op(cdq_pkg::KIND_PUSH_FRONT, 32'h7FFF_FFFF);
    send_op(cdq_pkg::KIND_PUSH_BACK, 32'h8000_0000);
    send_op(cdq_pkg::KIND_POP_BACK, $urandom);
    send_op(cdq_pkg::KIND_POP_FRONT, $urandom);
    // Fill from both ends so the indices wrap, then overflow from each end.
    for (int i = 0; i < cdq_pkg::DEPTH; i++) begin
      v = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
      send_op((i % 2 == 0) ? cdq_pkg::KIND_PUSH_FRONT : cdq_pkg::KIND_PUSH_BACK, v);
    end
    send_op(cdq_pkg::KIND_PUSH_FRONT, 32'h1234_5678);
    send_op(cdq_pkg::KIND_PUSH_BACK, 32'h8765_4321);

    // Runs with a changing push bias walk the deque between empty and full.
    while (sent < OP_TARGET) begin
      push_pct = $urandom_range(5, 95);
      run_len = $urandom_range(20, 60);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
      repeat (run_len) begin
        if ($urandom_range(1, 100) <= push_pct)
          k = cdq_pkg::kind_t'($urandom_range(0, 1));
        else
          k = cdq_pkg::kind_t'($urandom_range(2, 3));
        case ($urandom_range(0, 9))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          default: v = $urandom;
        endcase
        send_op(k, v);
      end
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
